// File: hw/rtl/multi_slot_software_timer_macros.svh
// assertion macros for the software timer table checker
// no dependencies; included by the checker file only
`ifndef MULTI_SLOT_SOFTWARE_TIMER_MACROS_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mst check failed");

// next-cycle implication, disabled while reset is low
`define MST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mst check failed");

`endif

// File: hw/rtl/mst_pkg.sv
// shared types and codes for the software timer table
// no dependencies; used by the cell, the top level and the checker
package mst_pkg;

    // item kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_SET     = 2'd1;
    localparam logic [1:0] KIND_CANCEL  = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // expiry actions
    localparam logic [1:0] ACT_CALLBACK = 2'd0;
    localparam logic [1:0] ACT_TOGGLE   = 2'd1;
    localparam logic [1:0] ACT_NONE     = 2'd2;

    // mode flag bit positions
    localparam int MODE_CALLBACK = 0;
    localparam int MODE_TOGGLE   = 1;
    localparam int MODE_CONT     = 2;

    // limits
    localparam int          MAX_RESULTS   = 8;
    localparam int          TICK_W        = 16;
    localparam logic [15:0] TIMEOUT_LIMIT = 16'(65535 / 2);

    typedef struct packed {
        logic [1:0]  kind;
        logic [14:0] timeout;
        logic        has_action;
        logic [2:0]  mode_flags;
        logic [3:0]  slot_select;
    } mst_in_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] slot;
        logic [3:0] active_count;
        logic       expired;
        logic [1:0] action;
        logic       running;
        logic       last;
    } mst_out_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              advance;
        logic [1:0]        op;
        logic              apply;
        logic [TICK_W-1:0] load;
        logic [2:0]        mode;
    } mst_ctl_t;

    // status of the cell holding the scan token, zero elsewhere
    typedef struct packed {
        logic       busy;
        logic       expiring;
        logic       cont;
        logic [1:0] action;
    } mst_rep_t;

    // expiry action from stored mode flags
    function automatic logic [1:0] action_of(input logic [2:0] mode);
        logic [1:0] act;
        if (mode[MODE_CALLBACK]) begin
            act = ACT_CALLBACK;
        end else if (mode[MODE_TOGGLE]) begin
            act = ACT_TOGGLE;
        end else begin
            act = ACT_NONE;
        end
        return act;
    endfunction

endpackage

// File: hw/rtl/mst_cell.sv
// one timer slot of the chain: counter, reload value, mode and scan token
// depends on mst_pkg
module mst_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  mst_pkg::mst_ctl_t ctl,
    input  logic              tok_i,
    output logic              tok_o,
    output mst_pkg::mst_rep_t rep_o
);
    import mst_pkg::*;

    logic [TICK_W-1:0] remaining_reg, remaining_next;
    logic [TICK_W-1:0] reload_reg, reload_next;
    logic [2:0]        mode_reg, mode_next;
    logic              tok_reg, tok_next;
    logic              busy;
    logic              expiring;

    assign busy     = (remaining_reg != '0);
    assign expiring = (remaining_reg == TICK_W'(1));

    // token shift on each step; slot update when the token is here, the step is taken and apply is set
    always_comb begin
        remaining_next = remaining_reg;
        reload_next    = reload_reg;
        mode_next      = mode_reg;
        tok_next       = ctl.advance ? tok_i : tok_reg;
        if (ctl.advance && tok_reg && ctl.apply) begin
            unique case (ctl.op)
                KIND_TICK: begin
                    if (expiring) begin
                        if (mode_reg[MODE_CONT]) begin
                            remaining_next = reload_reg;
                        end else begin
                            remaining_next = '0;
                            reload_next    = '0;
                            mode_next      = '0;
                        end
                    end else if (busy) begin
                        remaining_next = remaining_reg - TICK_W'(1);
                    end
                end
                KIND_SET: begin
                    remaining_next = ctl.load;
                    reload_next    = ctl.mode[MODE_CONT] ? ctl.load : '0;
                    mode_next      = ctl.mode;
                end
                KIND_CANCEL: begin
                    remaining_next = '0;
                    reload_next    = '0;
                    mode_next      = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= '0;
            reload_reg    <= '0;
            mode_reg      <= '0;
            tok_reg       <= 1'b0;
        end else begin
            remaining_reg <= remaining_next;
            reload_reg    <= reload_next;
            mode_reg      <= mode_next;
            tok_reg       <= tok_next;
        end
    end

    // token hand-off and status report
    assign tok_o = tok_reg;

    always_comb begin
        rep_o = '0;
        if (tok_reg) begin
            rep_o.busy     = busy;
            rep_o.expiring = expiring;
            rep_o.cont     = mode_reg[MODE_CONT];
            rep_o.action   = action_of(mode_reg);
        end
    end

endmodule

// File: hw/rtl/multi_slot_software_timer.sv
// software timer table: a row of SLOT_COUNT slot cells visited by a scan token
// one item passes through accept, one scan step per cell and result,
// or accept and result for an unknown kind; a tick stalls its scan while the output waits
// the next item is accepted in the cycle after the last result is registered
// synchronous active-low reset frees all slots and clears the count and token
module multi_slot_software_timer #(
    parameter int SLOT_COUNT = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mst_pkg::mst_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mst_pkg::mst_out_t m_data
);
    import mst_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int NR_W  = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]       state_reg, state_next;
    mst_in_t          cmd_reg, cmd_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] found_reg, found_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] count_after;
    logic [NR_W-1:0]  n_reg, n_next;
    logic             taken_reg, taken_next;
    logic             hold_valid_reg, hold_valid_next;
    mst_out_t         hold_reg, hold_next;
    logic             m_valid_reg, m_valid_next;
    mst_out_t         m_data_reg, m_data_next;

    mst_ctl_t         ctl;
    mst_rep_t         rep;
    mst_rep_t         rep_arr [SLOT_COUNT];
    logic [SLOT_COUNT:0] tok_chain;
    logic             launch;
    logic             out_free;
    logic             set_ok;
    logic             sel_hit;
    logic             sel_in_range;
    logic             push;
    logic [IDX_W+2:0] idx_ext;
    logic [IDX_W+2:0] found_ext;
    logic [IDX_W+3:0] idx_wide;
    logic [IDX_W+3:0] sel_wide;

    // active count shown on a result, saturated at 15
    function automatic logic [3:0] sat_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+3:0] c_ext;
        c_ext = {4'b0, c};
        return (c_ext > (CNT_W + 4)'(15)) ? 4'hF : c_ext[3:0];
    endfunction

    // chain of slot cells
    assign tok_chain[0] = launch;

    genvar g;
    generate
        for (g = 0; g < SLOT_COUNT; g++) begin : g_cell
            mst_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ctl),
                .tok_i   (tok_chain[g]),
                .tok_o   (tok_chain[g+1]),
                .rep_o   (rep_arr[g])
            );
        end
    endgenerate

    // only the token holder reports, so an or gives its status
    always_comb begin
        rep = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            rep = rep | rep_arr[i];
        end
    end

    // decode helpers
    assign idx_ext      = {3'b0, idx_reg};
    assign found_ext    = {3'b0, found_reg};
    assign idx_wide     = {4'b0, idx_reg};
    assign sel_wide     = {IDX_W'(0), cmd_reg.slot_select};
    assign sel_hit      = (idx_wide == sel_wide);
    assign sel_in_range = (sel_wide < (IDX_W + 4)'(SLOT_COUNT));
    assign set_ok       = (cmd_reg.timeout != '0) &&
                          ({1'b0, cmd_reg.timeout} <= TIMEOUT_LIMIT) &&
                          cmd_reg.has_action;
    assign count_after  = rep.cont ? count_reg : (count_reg - CNT_W'(1));
    assign out_free     = !m_valid_reg || m_ready;
    assign push         = rep.expiring && (n_reg < NR_W'(MAX_RESULTS));

    // controller
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        taken_next      = taken_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        launch          = 1'b0;
        ctl.advance     = 1'b0;
        ctl.op          = cmd_reg.kind;
        ctl.apply       = 1'b0;
        ctl.load        = {cmd_reg.timeout, 1'b0};
        ctl.mode        = cmd_reg.mode_flags;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next        = s_data;
                    idx_next        = '0;
                    n_next          = '0;
                    taken_next      = 1'b0;
                    hold_valid_next = 1'b0;
                    if (s_data.kind == KIND_UNKNOWN) begin
                        state_next = ST_FLUSH;
                    end else begin
                        launch      = 1'b1;
                        ctl.advance = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                case (cmd_reg.kind)
                    KIND_TICK: begin
                        ctl.apply = 1'b1;
                        if (!(push && hold_valid_reg && !out_free)) begin
                            ctl.advance = 1'b1;
                            if (rep.expiring) begin
                                count_next = count_after;
                            end
                            if (push) begin
                                if (hold_valid_reg) begin
                                    m_data_next  = hold_reg;
                                    m_valid_next = 1'b1;
                                end
                                hold_next.ok           = 1'b1;
                                hold_next.slot         = idx_ext[2:0];
                                hold_next.active_count = sat_count(count_after);
                                hold_next.expired      = 1'b1;
                                hold_next.action       = rep.action;
                                hold_next.running      = (count_after != '0);
                                hold_next.last         = 1'b0;
                                hold_valid_next        = 1'b1;
                                n_next                 = n_reg + NR_W'(1);
                            end
                        end
                    end
                    KIND_SET: begin
                        ctl.advance = 1'b1;
                        if (set_ok && !taken_reg && !rep.busy) begin
                            ctl.apply  = 1'b1;
                            taken_next = 1'b1;
                            found_next = idx_reg;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    KIND_CANCEL: begin
                        ctl.advance = 1'b1;
                        ctl.apply   = sel_hit;
                        if (sel_hit && rep.busy && (count_reg != '0)) begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    default: begin
                        ctl.advance = 1'b1;
                    end
                endcase
                if (ctl.advance) begin
                    idx_next = idx_reg + IDX_W'(1);
                    if (tok_chain[SLOT_COUNT]) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next              = '0;
                    m_data_next.active_count = sat_count(count_reg);
                    m_data_next.running      = (count_reg != '0);
                    m_data_next.last         = 1'b1;
                    case (cmd_reg.kind)
                        KIND_TICK: begin
                            if (hold_valid_reg) begin
                                m_data_next      = hold_reg;
                                m_data_next.last = 1'b1;
                            end else begin
                                m_data_next.ok = 1'b1;
                            end
                        end
                        KIND_SET: begin
                            if (taken_reg) begin
                                m_data_next.ok   = 1'b1;
                                m_data_next.slot = found_ext[2:0];
                            end
                        end
                        KIND_CANCEL: begin
                            if (sel_in_range) begin
                                m_data_next.ok   = 1'b1;
                                m_data_next.slot = cmd_reg.slot_select[2:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            count_reg      <= '0;
            n_reg          <= '0;
            taken_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            n_reg          <= n_next;
            taken_reg      <= taken_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        found_reg  <= found_next;
        hold_reg   <= hold_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hw/rtl/mst_checker.sv
// port-level checks for the software timer table, bound to the top level
// depends on mst_pkg and multi_slot_software_timer_macros.svh
`include "multi_slot_software_timer_macros.svh"

module mst_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input mst_pkg::mst_out_t m_data
);

    // a stalled result holds
    `MST_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // the block works on one item at a time
    `MST_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_valid && s_ready, !s_ready)

    // running flag agrees with the active count
    `MST_ASSERT_NOW(a_idle_count, aclk, aresetn, m_valid && !m_data.running, m_data.active_count == 4'd0)

    // an expiry report is always a success
    `MST_ASSERT_NOW(a_expiry_ok, aclk, aresetn, m_valid && m_data.expired, m_data.ok)

    // action is meaningful only on an expiry
    `MST_ASSERT_NOW(a_action_zero, aclk, aresetn, m_valid && !m_data.expired, m_data.action == 2'd0)

endmodule

bind multi_slot_software_timer mst_checker u_mst_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: tb/testbench.sv
// self-checking testbench for the software timer table, multi_slot_software_timer
// depends on mst_pkg for the transfer structs, item kinds and action codes
// drives directed items, then four phases of random items under varied handshake pressure
module testbench;
    import mst_pkg::*;

    localparam int SLOTS       = 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 55;

    // tracks the slot table and holds the results still owed by the block
    class timer_table_tracker;
        mst_out_t    due_results[$];
        logic [15:0] remaining[SLOTS];
        logic [15:0] reload[SLOTS];
        logic [2:0]  mode[SLOTS];
        int unsigned busy_total;
        int          errors;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                remaining[i] = '0;
                reload[i]    = '0;
                mode[i]      = '0;
            end
            busy_total = 0;
            errors     = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endfunction

        function string describe(mst_out_t r);
            return $sformatf("ok=%0d slot=%0d count=%0d expired=%0d action=%0d running=%0d last=%0d",
                             r.ok, r.slot, r.active_count, r.expired, r.action, r.running, r.last);
        endfunction

        // count and running reflect the table at the moment the result is formed
        function void owe(logic ok, logic [2:0] slot, logic expired, logic [1:0] action,
                          logic last);
            mst_out_t r;
            r.ok           = ok;
            r.slot         = slot;
            r.active_count = (busy_total > 15) ? 4'd15 : 4'(busy_total);
            r.expired      = expired;
            r.action       = action;
            r.running      = (busy_total != 0);
            r.last         = last;
            due_results.push_back(r);
        endfunction

        // advance the table by one accepted input transfer
        function void apply_item(mst_in_t it);
            logic [1:0] act;
            int         fired;
            fired = 0;
            case (it.kind)
                KIND_SET: begin
                    if (it.timeout != 0 && 16'(it.timeout) <= TIMEOUT_LIMIT && it.has_action) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (remaining[i] == 0) begin
                                remaining[i] = {it.timeout, 1'b0};
                                reload[i]    = it.mode_flags[MODE_CONT] ? {it.timeout, 1'b0} : 16'd0;
                                mode[i]      = it.mode_flags;
                                busy_total++;
                                owe(1'b1, 3'(i), 1'b0, 2'd0, 1'b1);
                                return;
                            end
                        end
                    end
                    owe(1'b0, 3'd0, 1'b0, 2'd0, 1'b1);
                end
                KIND_CANCEL: begin
                    if (int'(it.slot_select) < SLOTS) begin
                        // an already free slot leaves the count alone
                        if (remaining[it.slot_select] != 0 && busy_total != 0) begin
                            busy_total--;
                        end
                        remaining[it.slot_select] = '0;
                        reload[it.slot_select]    = '0;
                        mode[it.slot_select]      = '0;
                        owe(1'b1, it.slot_select[2:0], 1'b0, 2'd0, 1'b1);
                    end else begin
                        owe(1'b0, 3'd0, 1'b0, 2'd0, 1'b1);
                    end
                end
                KIND_TICK: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (remaining[i] != 0) begin
                            remaining[i] = remaining[i] - 16'd1;
                            if (remaining[i] == 0) begin
                                if (mode[i][MODE_CALLBACK]) begin
                                    act = ACT_CALLBACK;
                                end else if (mode[i][MODE_TOGGLE]) begin
                                    act = ACT_TOGGLE;
                                end else begin
                                    act = ACT_NONE;
                                end
                                // continuous slots reload, one-shot slots are freed
                                if (mode[i][MODE_CONT]) begin
                                    remaining[i] = reload[i];
                                end else begin
                                    if (busy_total != 0) begin
                                        busy_total--;
                                    end
                                    reload[i] = '0;
                                    mode[i]   = '0;
                                end
                                if (fired < MAX_RESULTS) begin
                                    owe(1'b1, 3'(i), 1'b1, act, 1'b0);
                                    fired++;
                                end
                            end
                        end
                    end
                    if (fired == 0) begin
                        owe(1'b1, 3'd0, 1'b0, 2'd0, 1'b1);
                    end else begin
                        due_results[due_results.size() - 1].last = 1'b1;
                    end
                end
                default: begin
                    owe(1'b0, 3'd0, 1'b0, 2'd0, 1'b1);
                end
            endcase
        endfunction

        // compare one output transfer with the oldest owed result
        function void match_result(mst_out_t got);
            mst_out_t want;
            string    bad;
            bad = "";
            if (due_results.size() == 0) begin
                flag($sformatf("unexpected result %s", describe(got)));
                return;
            end
            want = due_results.pop_front();
            if (got.ok !== want.ok)                     bad = {bad, " ok"};
            if (got.slot !== want.slot)                 bad = {bad, " slot"};
            if (got.active_count !== want.active_count) bad = {bad, " active_count"};
            if (got.expired !== want.expired)           bad = {bad, " expired"};
            if (got.action !== want.action)             bad = {bad, " action"};
            if (got.running !== want.running)           bad = {bad, " running"};
            if (got.last !== want.last)                 bad = {bad, " last"};
            if (bad != "") begin
                flag($sformatf("field(s)%s: expected %s, got %s", bad, describe(want),
                               describe(got)));
            end
        endfunction
    endclass

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    mst_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    mst_out_t m_data;

    timer_table_tracker tracker;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;

    multi_slot_software_timer #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // result side: random stalls, plus a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.match_result(m_data);
        end
    end

    // watchdog: ends the run after a long stretch with no transfer on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("multi_slot_software_timer regression: fail");
        $finish;
    end

    function automatic mst_in_t build_item(logic [1:0] kind, logic [14:0] timeout,
                                           logic has_action, logic [2:0] mode_flags,
                                           logic [3:0] slot_select);
        mst_in_t it;
        it.kind        = kind;
        it.timeout     = timeout;
        it.has_action  = has_action;
        it.mode_flags  = mode_flags;
        it.slot_select = slot_select;
        return it;
    endfunction

    // mixed kinds; sets mostly well-formed with short timeouts so expiries come often
    function automatic mst_in_t random_item();
        mst_in_t it;
        int      pick;
        it   = mst_in_t'(25'($urandom));
        pick = $urandom_range(99);
        if (pick < 45) begin
            it.kind = KIND_TICK;
        end else if (pick < 75) begin
            it.kind = KIND_SET;
            pick    = $urandom_range(99);
            if (pick < 70) begin
                it.timeout = 15'($urandom_range(6, 1));
            end else if (pick < 78) begin
                it.timeout = '0;
            end else if (pick < 83) begin
                it.timeout = '1;
            end else begin
                it.timeout = 15'($urandom);
            end
            it.has_action = ($urandom_range(99) < 90);
        end else if (pick < 95) begin
            it.kind = KIND_CANCEL;
            if ($urandom_range(99) < 80) begin
                it.slot_select = 4'($urandom_range(SLOTS - 1));
            end else begin
                it.slot_select = 4'($urandom_range(15, SLOTS));
            end
        end else begin
            it.kind = KIND_UNKNOWN;
        end
        return it;
    endfunction

    // offer one item, with random idle cycles ahead of it, and wait for its transfer
    task automatic send_item(input mst_in_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        tracker.apply_item(it);
    endtask

    // stop offering and wait until every owed result has arrived
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (PHASE_ITEMS) begin
            send_item(random_item());
        end
        drain();
    endtask

    initial begin
        tracker = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: failures, edge fields, a full table and a full expiry burst
        send_item(build_item(KIND_TICK, 15'd0, 1'b0, 3'd0, 4'd0));
        send_item(build_item(KIND_SET, 15'd0, 1'b1, 3'd1, 4'd0));
        send_item(build_item(KIND_SET, 15'd5, 1'b0, 3'd1, 4'd0));
        send_item(build_item(KIND_UNKNOWN, '1, 1'b1, 3'd7, 4'd15));
        send_item(build_item(KIND_CANCEL, 15'd0, 1'b0, 3'd0, 4'd15));
        send_item(build_item(KIND_CANCEL, 15'd0, 1'b0, 3'd0, 4'd8));
        send_item(build_item(KIND_CANCEL, 15'd0, 1'b0, 3'd0, 4'd3));
        for (int m = 0; m < SLOTS; m++) begin
            send_item(build_item(KIND_SET, 15'd1, 1'b1, 3'(m), 4'(m)));
        end
        send_item(build_item(KIND_SET, '1, 1'b1, 3'd7, 4'd0));
        send_item(build_item(KIND_TICK, 15'd0, 1'b0, 3'd0, 4'd0));
        send_item(build_item(KIND_TICK, 15'd0, 1'b0, 3'd0, 4'd0));
        send_item(build_item(KIND_SET, '1, 1'b1, 3'd3, 4'd0));
        send_item(build_item(KIND_CANCEL, 15'd0, 1'b0, 3'd0, 4'd5));
        send_item(build_item(KIND_CANCEL, 15'd0, 1'b0, 3'd0, 4'd5));
        send_item(build_item(KIND_TICK, 15'd0, 1'b0, 3'd0, 4'd0));
        send_item(build_item(KIND_TICK, 15'd0, 1'b0, 3'd0, 4'd0));
        send_item(build_item(KIND_CANCEL, 15'd0, 1'b0, 3'd0, 4'd0));
        drain();

        // random phases; the first opens with a long receiver hold-off
        hold_request = HOLD_CYCLES;
        run_phase(0, 0);
        run_phase(76, 0);
        run_phase(0, 76);
        run_phase(15, 15);

        repeat (SLOTS + 4) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("multi_slot_software_timer regression: pass");
        end else begin
            $display("multi_slot_software_timer regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/mst_pkg.sv
hw/rtl/mst_cell.sv
hw/rtl/multi_slot_software_timer.sv
hw/rtl/mst_checker.sv
tb/testbench.sv
